>>> hdl/tss_pkg.sv
// Shared types, token codes and helper functions for the token scanner.
`timescale 1ns / 1ps
package tss_pkg;

    // Token kinds
    localparam logic [5:0] K_CHAR   = 6'd0;
    localparam logic [5:0] K_SEMI   = 6'd1;
    localparam logic [5:0] K_NUM    = 6'd2;
    localparam logic [5:0] K_REAL   = 6'd3;
    localparam logic [5:0] K_IDENT  = 6'd4;
    localparam logic [5:0] K_IF     = 6'd5;
    localparam logic [5:0] K_ELSE   = 6'd6;
    localparam logic [5:0] K_FOR    = 6'd7;
    localparam logic [5:0] K_BREAK  = 6'd8;
    localparam logic [5:0] K_CONT   = 6'd9;
    localparam logic [5:0] K_FUNC   = 6'd10;
    localparam logic [5:0] K_RETURN = 6'd11;
    localparam logic [5:0] K_TRUE   = 6'd12;
    localparam logic [5:0] K_FALSE  = 6'd13;
    localparam logic [5:0] K_STRING = 6'd14;
    localparam logic [5:0] K_OROR   = 6'd15;
    localparam logic [5:0] K_ANDAND = 6'd17;
    localparam logic [5:0] K_EQEQ   = 6'd19;
    localparam logic [5:0] K_PLUSEQ = 6'd21;
    localparam logic [5:0] K_MINEQ  = 6'd23;
    localparam logic [5:0] K_MULEQ  = 6'd25;
    localparam logic [5:0] K_DIVEQ  = 6'd27;
    localparam logic [5:0] K_MODEQ  = 6'd29;
    localparam logic [5:0] K_GE     = 6'd31;
    localparam logic [5:0] K_LE     = 6'd33;
    localparam logic [5:0] K_NE     = 6'd35;
    localparam logic [5:0] K_LPAR   = 6'd37;
    localparam logic [5:0] K_RPAR   = 6'd38;
    localparam logic [5:0] K_LBRACE = 6'd39;
    localparam logic [5:0] K_RBRACE = 6'd40;
    localparam logic [5:0] K_LBRACK = 6'd41;
    localparam logic [5:0] K_RBRACK = 6'd42;
    localparam logic [5:0] K_COMMA  = 6'd43;
    localparam logic [5:0] K_END    = 6'd44;
    localparam logic [5:0] K_ERROR  = 6'd45;

    // Scanner modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_INT    = 3'd1;
    localparam logic [2:0] M_FRAC   = 3'd2;
    localparam logic [2:0] M_IDENT  = 3'd3;
    localparam logic [2:0] M_STRING = 3'd4;
    localparam logic [2:0] M_ESCAPE = 3'd5;
    localparam logic [2:0] M_OPER   = 3'd6;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic [30:0] iv;
        logic [29:0] fv;
        logic [3:0]  fd;
        logic [31:0] line;
        logic        last;
    } res_t;

    // Core to output queue: up to two results per transaction
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_out_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return (c == "|") || (c == "&") || (c == "=") || (c == "+") || (c == "-") ||
               (c == "*") || (c == "/") || (c == "%") || (c == ">") || (c == "<") ||
               (c == "!");
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] op, input logic paired);
        logic [5:0] base;
        case (op)
            "|":     base = K_OROR;
            "&":     base = K_ANDAND;
            "=":     base = K_EQEQ;
            "+":     base = K_PLUSEQ;
            "-":     base = K_MINEQ;
            "*":     base = K_MULEQ;
            "/":     base = K_DIVEQ;
            "%":     base = K_MODEQ;
            ">":     base = K_GE;
            "<":     base = K_LE;
            default: base = K_NE;
        endcase
        return paired ? base : base + 6'd1;
    endfunction

    // Window holds first char in the low byte; unused bytes are zero.
    function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [3:0] len);
        logic [63:0] r;
        logic [5:0]  k;
        for (int i = 0; i < 8; i++) begin
            r[63 - 8*i -: 8] = w[8*i +: 8];
        end
        k = K_IDENT;
        case (len)
            4'd2: if (r[63:48] == "if") k = K_IF;
            4'd3: if (r[63:40] == "for") k = K_FOR;
            4'd4: begin
                if (r[63:32] == "else") k = K_ELSE;
                else if (r[63:32] == "func") k = K_FUNC;
                else if (r[63:32] == "true") k = K_TRUE;
            end
            4'd5: begin
                if (r[63:24] == "break") k = K_BREAK;
                else if (r[63:24] == "false") k = K_FALSE;
            end
            4'd6: if (r[63:16] == "return") k = K_RETURN;
            4'd8: if (r == "continue") k = K_CONT;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic needs_semi(input logic [5:0] k);
        return (k == K_IDENT) || (k == K_NUM) || (k == K_REAL) || (k == K_TRUE) ||
               (k == K_FALSE) || (k == K_RPAR) || (k == K_RBRACE) || (k == K_BREAK) ||
               (k == K_RETURN) || (k == K_CONT);
    endfunction

endpackage

>>> hdl/tss_core.sv
// Scanner state and combinational step logic for one source transaction.
`timescale 1ns / 1ps
module tss_core #(
    parameter int KEYWORD_CHARS   = 8,
    parameter int FRAC_DIGITS_MAX = 9,
    parameter int INT_BITS        = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [7:0]         src_byte,
    input  logic               src_end,
    output tss_pkg::step_out_t step_out
);
    import tss_pkg::*;

    localparam int FRAC_W = 4 * FRAC_DIGITS_MAX;
    localparam int FC_W   = $clog2(FRAC_DIGITS_MAX + 1);
    localparam int KW_IW  = $clog2(KEYWORD_CHARS);
    localparam logic [INT_BITS-1:0] INT_MAX = '1;

    logic [2:0]          mode_reg, mode_next;
    logic [INT_BITS-1:0] acc_reg, acc_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [FC_W-1:0]     fcnt_reg, fcnt_next;
    logic [7:0]          win_reg [KEYWORD_CHARS];
    logic [7:0]          win_next [KEYWORD_CHARS];
    logic [3:0]          ilen_reg, ilen_next;
    logic [7:0]          pop_reg, pop_next;
    logic [5:0]          prev_reg, prev_next;
    logic [31:0]         line_reg, line_next;

    logic [63:0]         win64;
    res_t                res [2];
    logic [1:0]          n;
    logic                again;
    logic [7:0]          esc_v;
    logic [7:0]          want;
    logic [7:0]          c;
    logic [3:0]          dig;

    function automatic logic [INT_BITS-1:0] add_digit(input logic [INT_BITS-1:0] a,
                                                      input logic [3:0] d);
        logic [INT_BITS+3:0] w;
        w = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{INT_BITS{1'b0}}, d};
        return (w > {4'b0, INT_MAX}) ? INT_MAX : w[INT_BITS-1:0];
    endfunction

    always_comb begin
        logic [63:0]  iw;
        logic [127:0] fw;
        logic [7:0]   cw;
        logic [5:0]   kk;
        mode_next = mode_reg; acc_next = acc_reg; frac_next = frac_reg;
        fcnt_next = fcnt_reg; win_next = win_reg; ilen_next = ilen_reg;
        pop_next = pop_reg; prev_next = prev_reg; line_next = line_reg;
        n = 2'd0; again = 1'b1; res[0] = '0; res[1] = '0;
        c = src_byte; dig = src_byte[3:0];
        iw = '0; fw = '0; cw = '0; kk = '0;
        win64 = '0;
        for (int i = 0; i < 8; i++) begin
            win64[8*i +: 8] = win_reg[i];
        end
        esc_v = 8'd0;
        want = ((pop_reg == "|") || (pop_reg == "&")) ? pop_reg : 8'("=");

        // first half: the open token consumes the byte or closes
        case (mode_reg)
            M_INT: begin
                if (!src_end && is_digit(c)) begin
                    acc_next = add_digit(acc_reg, dig); again = 1'b0;
                end else if (!src_end && c == ".") begin
                    mode_next = M_FRAC; again = 1'b0;
                end else begin
                    iw = 64'(acc_reg);
                    res[0] = '{kind: K_NUM, ch: 8'd0, iv: iw[30:0], fv: 30'd0, fd: 4'd0,
                               line: line_next, last: 1'b0};
                    n = 2'd1;
                end
            end
            M_FRAC: begin
                if (!src_end && is_digit(c)) begin
                    if (fcnt_reg < FC_W'(FRAC_DIGITS_MAX)) begin
                        frac_next = (frac_reg << 3) + (frac_reg << 1) + FRAC_W'(dig);
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    again = 1'b0;
                end else begin
                    iw = 64'(acc_reg); fw = 128'(frac_reg); cw = 8'(fcnt_reg);
                    res[0] = '{kind: K_REAL, ch: 8'd0, iv: iw[30:0], fv: fw[29:0],
                               fd: cw[3:0], line: line_next, last: 1'b0};
                    n = 2'd1;
                end
            end
            M_IDENT: begin
                if (!src_end && (is_alpha(c) || is_digit(c))) begin
                    if ({1'b0, ilen_reg} < 5'(KEYWORD_CHARS))
                        win_next[ilen_reg[KW_IW-1:0]] = c;
                    if (ilen_reg != 4'd15) ilen_next = ilen_reg + 4'd1;
                    res[0] = '{kind: K_CHAR, ch: c, iv: '0, fv: '0, fd: '0,
                               line: line_next, last: 1'b0};
                    n = 2'd1; again = 1'b0;
                end else begin
                    res[0] = '{kind: word_kind(win64, ilen_reg), ch: '0, iv: '0, fv: '0,
                               fd: '0, line: line_next, last: 1'b0};
                    n = 2'd1;
                end
            end
            M_STRING: begin
                if (src_end) begin
                    res[0] = '{kind: K_ERROR, ch: '0, iv: '0, fv: '0, fd: '0,
                               line: line_next, last: 1'b0};
                    n = 2'd1;
                end else begin
                    again = 1'b0;
                    if (c == "\"") begin
                        res[0] = '{kind: K_STRING, ch: '0, iv: '0, fv: '0, fd: '0,
                                   line: line_next, last: 1'b0};
                        n = 2'd1; mode_next = M_IDLE;
                    end else if (c == "\\") begin
                        mode_next = M_ESCAPE;
                    end else begin
                        res[0] = '{kind: K_CHAR, ch: c, iv: '0, fv: '0, fd: '0,
                                   line: line_next, last: 1'b0};
                        n = 2'd1;
                    end
                end
            end
            M_ESCAPE: begin
                if (!src_end) begin
                    case (c)
                        "n":     esc_v = 8'd10;
                        "t":     esc_v = 8'd9;
                        "b":     esc_v = 8'd8;
                        "f":     esc_v = 8'd12;
                        "r":     esc_v = 8'd13;
                        "\"":    esc_v = 8'd34;
                        "\\":    esc_v = 8'd92;
                        default: esc_v = 8'd0;
                    endcase
                end
                if (esc_v != 8'd0) begin
                    res[0] = '{kind: K_CHAR, ch: esc_v, iv: '0, fv: '0, fd: '0,
                               line: line_next, last: 1'b0};
                    n = 2'd1; mode_next = M_STRING; again = 1'b0;
                end else begin
                    res[0] = '{kind: K_ERROR, ch: '0, iv: '0, fv: '0, fd: '0,
                               line: line_next, last: 1'b0};
                    n = 2'd1;
                end
            end
            M_OPER: begin
                if (!src_end && c == want) begin
                    kk = op_kind(pop_reg, 1'b1);
                    mode_next = M_IDLE; again = 1'b0;
                end else begin
                    kk = op_kind(pop_reg, 1'b0);
                end
                res[0] = '{kind: kk, ch: '0, iv: '0, fv: '0, fd: '0,
                           line: line_next, last: 1'b0};
                n = 2'd1; pop_next = 8'd0;
            end
            default: ;
        endcase

        if (n != 2'd0 && res[0].kind != K_CHAR) prev_next = res[0].kind;

        // second half: byte handled between tokens
        if (again) begin
            mode_next = M_IDLE;
            kk = K_CHAR;
            if (src_end) begin
                kk = K_END;
            end else if (c == " " || c == "\t") begin
                kk = K_CHAR;
            end else if (c == "\n") begin
                if (line_reg != 32'hFFFF_FFFF) line_next = line_reg + 32'd1;
                if (needs_semi(prev_next)) kk = K_SEMI;
            end else if (is_digit(c) || c == ".") begin
                frac_next = '0; fcnt_next = '0;
                if (c == ".") begin
                    acc_next = '0; mode_next = M_FRAC;
                end else begin
                    acc_next = add_digit('0, dig); mode_next = M_INT;
                end
            end else if (is_alpha(c)) begin
                for (int i = 0; i < KEYWORD_CHARS; i++) win_next[i] = 8'd0;
                win_next[0] = c; ilen_next = 4'd1; mode_next = M_IDENT;
                res[n[0]] = '{kind: K_CHAR, ch: c, iv: '0, fv: '0, fd: '0,
                              line: line_next, last: 1'b0};
                n = n + 2'd1;
            end else if (c == "\"") begin
                mode_next = M_STRING;
            end else if (is_op_start(c)) begin
                pop_next = c; mode_next = M_OPER;
            end else begin
                case (c)
                    "(":     kk = K_LPAR;
                    ")":     kk = K_RPAR;
                    "{":     kk = K_LBRACE;
                    "}":     kk = K_RBRACE;
                    "[":     kk = K_LBRACK;
                    "]":     kk = K_RBRACK;
                    ";":     kk = K_SEMI;
                    ",":     kk = K_COMMA;
                    default: kk = K_ERROR;
                endcase
            end
            if (kk != K_CHAR) begin
                res[n[0]] = '{kind: kk, ch: '0, iv: '0, fv: '0, fd: '0,
                              line: line_next, last: 1'b0};
                n = n + 2'd1;
                prev_next = kk;
            end
        end

        if (n == 2'd1) res[0].last = 1'b1;
        if (n == 2'd2) res[1].last = 1'b1;
    end

    assign step_out = '{count: n, r0: res[0], r1: res[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            acc_reg  <= '0;
            frac_reg <= '0;
            fcnt_reg <= '0;
            for (int i = 0; i < KEYWORD_CHARS; i++) win_reg[i] <= 8'd0;
            ilen_reg <= 4'd0;
            pop_reg  <= 8'd0;
            prev_reg <= K_CHAR;
            line_reg <= 32'd1;
        end else if (step_en) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            frac_reg <= frac_next;
            fcnt_reg <= fcnt_next;
            win_reg  <= win_next;
            ilen_reg <= ilen_next;
            pop_reg  <= pop_next;
            prev_reg <= prev_next;
            line_reg <= line_next;
        end
    end

endmodule

>>> hdl/token_scanner_with_semicolon_insert.sv
// Top level of the streaming token scanner with semicolon insertion.
`timescale 1ns / 1ps
// Streaming lexer: one source byte (or end mark on s_axis_tuser) per input
// transaction, accepted every cycle while the result queue has room for two
// results. Each byte is scanned in the same cycle it is accepted; the scanner
// state updates at that edge, and the zero to two tokens it causes go into a
// four-entry result queue. The output side drains one token per cycle while
// m_axis_tready is high, so the sustained rate is one byte per cycle while
// bytes average at most one token (identifier and string characters, closing
// tokens); a byte that makes two tokens queues both. m_axis_tlast marks the
// final token produced by a byte. Newlines after identifiers, numbers, reals,
// true, false, ')', '}', break, return or continue add a semicolon token.
module token_scanner_with_semicolon_insert #(
    parameter int KEYWORD_CHARS   = 8,
    parameter int FRAC_DIGITS_MAX = 9,
    parameter int INT_BITS        = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] source_byte
    input  logic         s_axis_tuser,   // [0] end_of_text
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [5:0] token_kind, [13:6] char_value, [44:14] int_value,
    // [74:45] frac_value, [78:75] frac_digits, [110:79] line_number, [111] zero
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_of_run
);
    import tss_pkg::*;

    step_out_t  step;
    logic       s_fire, m_fire;
    res_t       q_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;
    res_t       head;

    assign s_axis_tready = (cnt_reg < 3'd3);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    tss_core #(
        .KEYWORD_CHARS  (KEYWORD_CHARS),
        .FRAC_DIGITS_MAX(FRAC_DIGITS_MAX),
        .INT_BITS       (INT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_fire),
        .src_byte(s_axis_tdata),
        .src_end (s_axis_tuser),
        .step_out(step)
    );

    // result queue
    always_comb begin
        cnt_next = cnt_reg;
        if (s_fire) cnt_next = cnt_next + 3'(step.count);
        if (m_fire) cnt_next = cnt_next - 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (s_fire && step.count != 2'd0) q_reg[wr_reg] <= step.r0;
        if (s_fire && step.count == 2'd2) q_reg[wr_reg + 2'd1] <= step.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            if (s_fire) wr_reg <= wr_reg + step.count;
            if (m_fire) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    assign head          = q_reg[rd_reg];
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = {1'b0, head.line, head.fd, head.fv, head.iv, head.ch, head.kind};
    assign m_axis_tlast  = head.last;

endmodule

>>> hdl/tss_checker.sv
// Port-level checker for the token scanner, bound to the top level.
`timescale 1ns / 1ps
module tss_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import tss_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[110:79] != 32'd0)
        else $error("line number zero");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[5:0] == K_END |-> m_axis_tlast)
        else $error("end token not last of its run");

endmodule

bind token_scanner_with_semicolon_insert tss_checker u_tss_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
